// ----- src/rhpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared types and constants of the rolling hash pattern matcher.
// ----------------------------------------------------------------------------
package rhpm_pkg;

    localparam int BYTE_W = 8;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] REG_HASH_BASE      = 2'd2;
    localparam logic [1:0] REG_MATCH_LIMIT    = 2'd3;

    localparam logic [3:0] RESET_LENGTH = 4'd1;
    localparam logic [7:0] RESET_BASE   = 8'd11;
    localparam logic [7:0] RESET_LIMIT  = 8'd2;
    localparam logic [7:0] OCC_MAX      = 8'hFF;

    // control shared by every cell of the window
    typedef struct packed {
        logic clear;   // start of text: zero the stored byte
        logic load;    // start of text: take pattern byte and active flag
        logic shift;   // take neighbour's byte (cell 0: the new text byte)
    } t_cell_ctl;

endpackage

// ----- src/rhpm_cell.sv -----
// ----------------------------------------------------------------------------
// rhpm_cell
// One window cell: holds a text byte and the pattern byte it is checked
// against; passes its byte to the next cell on every shift.
// ----------------------------------------------------------------------------
module rhpm_cell #(
    parameter bit RESET_ACTIVE = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rhpm_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]          i_shift_in,
    input  logic [7:0]          i_pattern,
    input  logic                i_active,
    output logic [7:0]          o_byte,
    output logic                o_equal
);
    import rhpm_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] r_pattern;
    logic              r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte    <= '0;
            r_pattern <= '0;
            r_active  <= RESET_ACTIVE;
        end else begin
            if (i_ctl.clear) begin
                r_byte <= '0;
            end else if (i_ctl.shift) begin
                r_byte <= i_shift_in;
            end
            if (i_ctl.load) begin
                r_pattern <= i_pattern;
                r_active  <= i_active;
            end
        end
    end

    assign o_byte  = r_byte;
    // unused cells beyond the pattern length never veto a match
    assign o_equal = !r_active || (r_byte == r_pattern);

endmodule

// ----- src/rolling_hash_pattern_matcher_core.sv -----
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher_core
// Rabin-Karp matcher: rolling hash over a chain of window cells, with a
// bytewise check of every hash hit and a saturating occurrence count.
// ----------------------------------------------------------------------------
// Sequence: accept, subtract, multiply, compare for each input beat; a
//   start-of-text beat first computes the pattern hash, a step per byte.
// Input: a byte is taken only after the last has passed compare, which holds
//   while the output stalls; the hash does outgoing-byte subtract, base multiply.
// Reset: synchronous active low; registers to their reset values, window
//   cleared, pattern latched as for the reset register values.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_matcher_core #(
    parameter int MAX_PATTERN   = 8,
    parameter int HASH_BITS     = 32,
    parameter int POSITION_BITS = 16,
    localparam int OUT_W = ((POSITION_BITS + 11 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // text stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0]        s_axis_tuser,   // [0] start_of_text
    // result stream out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // hash_hit, match, match_start,
                                              // occurrence_count, limit_reached
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import rhpm_pkg::*;

    localparam int CNT_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int PAT_W  = MAX_PATTERN * BYTE_W;
    localparam int PROD_W = HASH_BITS + BYTE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LATCH,
        S_SUB,
        S_MUL,
        S_CMP
    } t_state;

    // configuration registers
    logic [63:0] r_pattern_bytes;
    logic [3:0]  r_pattern_length;
    logic [7:0]  r_hash_base;
    logic [7:0]  r_match_limit;

    // latched text context
    t_state               r_state;
    logic [BYTE_W-1:0]    r_byte;
    logic [LEN_W-1:0]     r_act_len;
    logic [7:0]           r_act_base;
    logic [PAT_W-1:0]     r_act_pattern;
    logic [HASH_BITS-1:0] r_pat_hash;
    logic [HASH_BITS-1:0] r_base_pow;
    logic [HASH_BITS-1:0] r_hash;
    logic [LEN_W-1:0]     r_fill;
    logic [CNT_W-1:0]     r_cnt;
    logic [POSITION_BITS-1:0] r_pos;
    logic [7:0]           r_occ;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    logic                 in_beat;
    logic                 cfg_wr;
    logic [LEN_W-1:0]     cfg_len;
    logic [BYTE_W-1:0]    old_byte;
    logic [HASH_BITS-1:0] mul_a;
    logic [PROD_W-1:0]    prod_a;
    logic [7:0]           mul_b;
    logic [PROD_W-1:0]    prod_b;
    logic                 full;
    logic                 hit;
    logic                 all_equal;
    logic                 n_good;
    logic [7:0]           n_occ;
    logic [POSITION_BITS-1:0] n_start;
    logic                 out_free;

    t_cell_ctl            cell_ctl;
    logic [BYTE_W-1:0]    cell_byte  [MAX_PATTERN];
    logic [BYTE_W-1:0]    cell_pat   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_act;
    logic [MAX_PATTERN-1:0] cell_eq;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;

    // -- APB register file -------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= RESET_LENGTH;
            r_hash_base      <= RESET_BASE;
            r_match_limit    <= RESET_LIMIT;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_PATTERN_BYTES:  r_pattern_bytes  <= pwdata;
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[3:0];
                REG_HASH_BASE:      r_hash_base      <= pwdata[7:0];
                REG_MATCH_LIMIT:    r_match_limit    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_PATTERN_BYTES:  prdata = r_pattern_bytes;
            REG_PATTERN_LENGTH: prdata = {60'd0, r_pattern_length};
            REG_HASH_BASE:      prdata = {56'd0, r_hash_base};
            REG_MATCH_LIMIT:    prdata = {56'd0, r_match_limit};
            default:            prdata = '0;
        endcase
    end

    // length 0 acts as 1, anything above the window depth as the depth
    always_comb begin
        if (r_pattern_length == 4'd0) begin
            cfg_len = LEN_W'(1);
        end else if (r_pattern_length > 4'(MAX_PATTERN)) begin
            cfg_len = LEN_W'(MAX_PATTERN);
        end else begin
            cfg_len = LEN_W'(r_pattern_length);
        end
    end

    // -- window chain --------------------------------------------------------
    // Cell i holds window[i] (newest byte in cell 0) and is checked against
    // pattern byte len-1-i, loaded at start of text.
    assign cell_ctl.clear = in_beat && s_axis_tuser[0];
    assign cell_ctl.load  = in_beat && s_axis_tuser[0];
    assign cell_ctl.shift = (r_state == S_MUL);

    for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
        always_comb begin
            cell_pat[gi] = '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (int'(cfg_len) - 1 - gi == j) begin
                    cell_pat[gi] = r_pattern_bytes[BYTE_W*j +: BYTE_W];
                end
            end
        end
        assign cell_act[gi] = (gi < int'(cfg_len));

        rhpm_cell #(
            .RESET_ACTIVE (gi == 0)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_shift_in ((gi == 0) ? r_byte : cell_byte[(gi == 0) ? 0 : gi - 1]),
            .i_pattern  (cell_pat[gi]),
            .i_active   (cell_act[gi]),
            .o_byte     (cell_byte[gi]),
            .o_equal    (cell_eq[gi])
        );
    end

    // byte leaving the window: the oldest of the active cells
    always_comb begin
        old_byte = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (int'(r_act_len) - 1 == i) begin
                old_byte = cell_byte[i];
            end
        end
    end

    // -- hash datapath -------------------------------------------------------
    // Multiplier A: hash times base (pattern hash while latching).
    // Multiplier B: base power times base while latching, else times old byte.
    assign mul_a  = (r_state == S_LATCH) ? r_pat_hash : r_hash;
    assign prod_a = mul_a * r_act_base;
    assign mul_b  = (r_state == S_LATCH) ? r_act_base : old_byte;
    assign prod_b = r_base_pow * mul_b;

    // -- result --------------------------------------------------------------
    assign full      = (r_fill >= r_act_len);
    assign hit       = full && (r_hash == r_pat_hash);
    assign all_equal = &cell_eq;
    // once the limit is reached no further matches are reported
    assign n_good    = hit && all_equal && (r_occ < r_match_limit);
    assign n_occ     = (n_good && (r_occ != OCC_MAX)) ? r_occ + 8'd1 : r_occ;
    assign n_start   = full ? r_pos - POSITION_BITS'(r_act_len - LEN_W'(1))
                            : '0;

    // -- sequencer -----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_byte        <= '0;
            r_act_len     <= LEN_W'(1);
            r_act_base    <= RESET_BASE;
            r_act_pattern <= '0;
            r_pat_hash    <= '0;
            r_base_pow    <= HASH_BITS'(1);
            r_hash        <= '0;
            r_fill        <= '0;
            r_cnt         <= '0;
            r_pos         <= '0;
            r_occ         <= '0;
            r_out_valid   <= 1'b0;
            r_out_data    <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_byte <= s_axis_tdata;
                        if (s_axis_tuser[0]) begin
                            r_hash        <= '0;
                            r_fill        <= '0;
                            r_pos         <= '0;
                            r_occ         <= '0;
                            r_act_len     <= cfg_len;
                            r_act_base    <= r_hash_base;
                            r_act_pattern <= r_pattern_bytes[PAT_W-1:0];
                            r_pat_hash    <= '0;
                            r_base_pow    <= HASH_BITS'(1);
                            r_cnt         <= '0;
                            r_state       <= S_LATCH;
                        end else begin
                            r_state <= S_SUB;
                        end
                    end
                end
                S_LATCH: begin
                    // Horner step over pattern byte r_cnt
                    r_pat_hash <= prod_a[HASH_BITS-1:0]
                                  + HASH_BITS'(r_act_pattern[BYTE_W*r_cnt +: BYTE_W]);
                    if (r_cnt != '0) begin
                        r_base_pow <= prod_b[HASH_BITS-1:0];
                    end
                    if (r_cnt == CNT_W'(r_act_len - LEN_W'(1))) begin
                        r_state <= S_SUB;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_SUB: begin
                    if (full) begin
                        r_hash <= r_hash - prod_b[HASH_BITS-1:0];
                    end else begin
                        r_fill <= r_fill + LEN_W'(1);
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_hash  <= prod_a[HASH_BITS-1:0] + HASH_BITS'(r_byte);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (out_free) begin
                        r_occ       <= n_occ;
                        r_pos       <= r_pos + POSITION_BITS'(1);
                        r_out_valid <= 1'b1;
                        r_out_data  <= OUT_W'({(n_occ >= r_match_limit), n_occ,
                                               n_start, n_good, hit});
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- src/rhpm_checker.sv -----
// ----------------------------------------------------------------------------
// rhpm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
module rhpm_checker #(
    parameter int POSITION_BITS = 16,
    localparam int OUT_W = ((POSITION_BITS + 11 + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             pready
);
    localparam int OCC_LO = POSITION_BITS + 2;

    // a confirmed match is always a hash hit
    a_match_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("match without hash hit");

    // a confirmed match has been counted
    a_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[OCC_LO +: 8] != 8'd0)
        else $error("match with zero count");

    // an input beat is followed by the hash sequence, so no beat follows straight on
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind rolling_hash_pattern_matcher_core rhpm_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_rhpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
